>>> rtl/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text console writer
// Assertions are clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// The condition must never be true outside reset.
`define TCW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Operation codes of an input request.
	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Control characters.
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Cell content after reset: a space with light grey on black.
	localparam logic [15:0] RESET_CELL = 16'h0720;

	// Register word indexes on the configuration port.
	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	// Widest values that the size parameters allow.
	localparam int ROW_MAX_W  = 6;
	localparam int COL_MAX_W  = 7;
	localparam int ADDR_MAX_W = 13;

	// Cursor update decided for one request.
	typedef struct packed {
		logic [ROW_MAX_W-1:0]  row;
		logic [COL_MAX_W-1:0]  col;
		logic                  we;
		logic [ADDR_MAX_W-1:0] waddr;
		logic [15:0]           wdata;
		logic                  scroll;
	} cur_upd_t;

endpackage

>>> rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Next cursor position and cell write for one request.
// ----------------------------------------------------------------------------
module tcw_cursor import tcw_pkg::*; #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  op_t                        op,
	input  logic [7:0]                 ch,
	input  logic [$clog2(ROWS)-1:0]    row,
	input  logic [$clog2(COLS)-1:0]    col,
	input  logic [7:0]                 attr,
	output cur_upd_t                   upd
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam int AW = $clog2(ROWS * COLS);
	localparam logic [RW:0]   ROWS_E = (RW + 1)'(ROWS);
	localparam logic [CW:0]   COLS_E = (CW + 1)'(COLS);
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
	localparam logic [AW-1:0] COLS_A = AW'(COLS);

	logic [RW:0]   row_inc;
	logic [CW:0]   col_inc;
	logic [CW:0]   tab_col;
	logic [RW-1:0] row_n;
	logic [CW-1:0] col_n;
	logic [RW-1:0] wr_row;
	logic [CW-1:0] wr_col;
	logic [7:0]    wr_ch;
	logic          we;
	logic          scroll;
	logic          adv_row;

	always_comb begin
		row_inc = {1'b0, row} + (RW + 1)'(1);
		col_inc = {1'b0, col} + (CW + 1)'(1);
		tab_col = {1'b0, col} + (CW + 1)'(8);
		tab_col[2:0] = 3'b000;
		row_n   = row;
		col_n   = col;
		wr_row  = row;
		wr_col  = col;
		wr_ch   = ch;
		we      = 1'b0;
		adv_row = 1'b0;
		scroll  = 1'b0;
		unique case (op)
			OP_CHAR: begin
				priority if (ch == CH_NL) begin
					adv_row = 1'b1;
				end else if (ch == CH_CR) begin
					col_n = '0;
				end else if (ch == CH_BS) begin
					wr_ch = CH_SPACE;
					if (col != '0) begin
						col_n  = col - CW'(1);
						wr_col = col - CW'(1);
						we     = 1'b1;
					end else if (row != '0) begin
						row_n  = row - RW'(1);
						col_n  = LAST_COL;
						wr_row = row - RW'(1);
						wr_col = LAST_COL;
						we     = 1'b1;
					end
				end else if (ch == CH_TAB) begin
					if (tab_col >= COLS_E) begin
						adv_row = 1'b1;
					end else begin
						col_n = tab_col[CW-1:0];
					end
				end else begin
					we = 1'b1;
					if (col_inc >= COLS_E) begin
						adv_row = 1'b1;
					end else begin
						col_n = col_inc[CW-1:0];
					end
				end
				// Moving past the last row scrolls and keeps the cursor on it.
				if (adv_row) begin
					col_n = '0;
					if (row_inc >= ROWS_E) begin
						row_n  = LAST_ROW;
						scroll = 1'b1;
					end else begin
						row_n = row_inc[RW-1:0];
					end
				end
			end
			OP_CLEAR: begin
				row_n = '0;
				col_n = '0;
			end
			OP_READ, OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign upd.row    = ROW_MAX_W'(row_n);
	assign upd.col    = COL_MAX_W'(col_n);
	assign upd.we     = we;
	assign upd.waddr  = ADDR_MAX_W'(AW'(wr_row) * COLS_A + AW'(wr_col));
	assign upd.wdata  = {attr, wr_ch};
	assign upd.scroll = scroll;

endmodule

>>> rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Teletype text console over a ROWS x COLS store of 16-bit character cells.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Fields
//   input     in_valid / in_ready        op, char_code, read_index
//   result    out_valid / out_ready      cursor_position, cursor_row,
//                                        cursor_col, scrolled, read_cell
//   config    psel, penable, pwrite      paddr, pwdata, prdata (pready high)
//
// Requests are handled one at a time around the single write port of the
// screen RAM. From acceptance, a character without scroll passes through
// the execute state; a read also passes through the registered RAM read and
// a state that parks the result; a clear fills every cell and a scroll copies
// the rows up and fills the bottom row, moving one cell per cycle. After reset
// a clearing pass writes the reset cell into all ROWS*COLS entries, one per
// cycle, before in_ready rises; configuration writes are taken during that
// pass. A stalled result stays in the output register and holds the next
// result back until it is taken.
//
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input requests.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  char_code,
	input  logic [10:0] read_index,
	// Results.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] cursor_position,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic        scrolled,
	output logic [15:0] read_cell,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CELLS = ROWS * COLS;
	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam int AW = $clog2(CELLS);
	localparam logic [AW-1:0] COLS_A     = AW'(COLS);
	localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_CNT   = AW'(CELLS - COLS);
	localparam logic [RW-1:0] MAX_ROW    = RW'(ROWS - 1);
	localparam logic [CW-1:0] MAX_COL    = CW'(COLS - 1);

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		S_INIT = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_EXEC = 7'b0000100,
		S_READ = 7'b0001000,
		S_COPY = 7'b0010000,
		S_FILL = 7'b0100000,
		S_WAIT = 7'b1000000
	} state_t;

	state_t        state_q;

	// Configuration registers.
	logic [3:0]    fg_q;
	logic [3:0]    bg_q;
	logic [7:0]    attr;

	// The request being worked on.
	op_t           op_q;
	logic [7:0]    ch_q;
	logic [10:0]   ridx_q;

	// Cursor and pending result.
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          scrolled_q;
	logic [15:0]   rd_q;

	// Sweep address and the copy write stage.
	logic [AW-1:0] cnt_q;
	logic          cp_valid_s1;
	logic [AW-1:0] cp_addr_s1;

	// Output register.
	logic          out_valid_q;
	logic [10:0]   pos_q;
	logic [4:0]    orow_q;
	logic [6:0]    ocol_q;
	logic          osc_q;
	logic [15:0]   ocell_q;

	cur_upd_t      upd;
	logic          slot_free;
	logic          load_out;
	logic          cfg_we;
	logic          rd_in_range;

	logic [RW-1:0] res_row;
	logic [CW-1:0] res_col;
	logic          res_sc;
	logic [AW-1:0] res_pos;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	assign attr = {bg_q, fg_q};

	// ------------------------------------------------------------------
	// Configuration port. Both registers sit in their own word; the low
	// address bits are not decoded.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_BG) ? {28'd0, bg_q} : {28'd0, fg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'd7;
			bg_q <= 4'd0;
		end else if (cfg_we) begin
			if (paddr[2] == REG_FG) begin
				fg_q <= pwdata[3:0];
			end else begin
				bg_q <= pwdata[3:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Cursor decision for the held request.
	// ------------------------------------------------------------------
	tcw_cursor #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_cursor (
		.op  (op_q),
		.ch  (ch_q),
		.row (row_q),
		.col (col_q),
		.attr(attr),
		.upd (upd)
	);

	// ------------------------------------------------------------------
	// Screen store. Accesses never overlap on one entry: a read request
	// writes nothing, and during the row copy every write lands at a lower
	// address than the cell that is being read.
	// ------------------------------------------------------------------
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = {attr, CH_SPACE};
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = RESET_CELL;
			end
			S_EXEC: begin
				ram_we    = upd.we;
				ram_waddr = upd.waddr[AW-1:0];
				ram_wdata = upd.wdata;
			end
			S_COPY: begin
				ram_we    = cp_valid_s1;
				ram_waddr = cp_addr_s1;
				ram_wdata = ram_rdata;
			end
			S_FILL: begin
				ram_we = 1'b1;
			end
			S_IDLE, S_READ, S_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	// The copy reads one row ahead of where it writes.
	assign ram_raddr = (state_q == S_COPY) ? AW'(cnt_q + COLS_A) : AW'(ridx_q);

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_in_range = 32'(ridx_q) < CELLS;

	// ------------------------------------------------------------------
	// Result selection. An ordinary character with a free output slot hands
	// its result straight from the cursor decision; every other path parks it
	// in the cursor and pending registers first.
	// ------------------------------------------------------------------
	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = slot_free &&
		((state_q == S_WAIT) ||
		 ((state_q == S_EXEC) && !upd.scroll && (op_q != OP_CLEAR) && (op_q != OP_READ)));

	always_comb begin
		if (state_q == S_EXEC) begin
			res_row = upd.row[RW-1:0];
			res_col = upd.col[CW-1:0];
			res_sc  = 1'b0;
		end else begin
			res_row = row_q;
			res_col = col_q;
			res_sc  = scrolled_q;
		end
		res_pos = AW'(res_row) * COLS_A + AW'(res_col);
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			cp_valid_s1 <= 1'b0;
			cp_addr_s1  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			scrolled_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					row_q      <= upd.row[RW-1:0];
					col_q      <= upd.col[CW-1:0];
					scrolled_q <= upd.scroll;
					cnt_q      <= '0;
					priority if (upd.scroll) begin
						state_q <= S_COPY;
					end else if (op_q == OP_CLEAR) begin
						state_q <= S_FILL;
					end else if (op_q == OP_READ) begin
						state_q <= S_READ;
					end else if (slot_free) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_READ: begin
					state_q <= S_WAIT;
				end
				S_COPY: begin
					// The write of the last copied cell happens in the
					// cycle that sees the read count run out.
					cp_addr_s1 <= cnt_q;
					if (cnt_q == COPY_CNT) begin
						cp_valid_s1 <= 1'b0;
						cnt_q       <= COPY_CNT;
						state_q     <= S_FILL;
					end else begin
						cp_valid_s1 <= 1'b1;
						cnt_q       <= cnt_q + AW'(1);
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == LAST_CELL) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request and read data registers carry payload only.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= op_t'(op);
			ch_q   <= char_code;
			ridx_q <= read_index;
			rd_q   <= '0;
		end else if (state_q == S_READ) begin
			rd_q <= rd_in_range ? ram_rdata : 16'd0;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pos_q   <= 11'(res_pos);
			orow_q  <= 5'(res_row);
			ocol_q  <= 7'(res_col);
			osc_q   <= res_sc;
			ocell_q <= (state_q == S_EXEC) ? 16'd0 : rd_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_position = pos_q;
	assign cursor_row      = orow_q;
	assign cursor_col      = ocol_q;
	assign scrolled        = osc_q;
	assign read_cell       = ocell_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`TCW_ASSERT(a_cursor_range, (row_q <= MAX_ROW) && (col_q <= MAX_COL), "cursor out of range")
	`TCW_NEVER(a_idle_no_write, ram_we && ((state_q == S_IDLE) || (state_q == S_WAIT)), "store written while idle")
	`TCW_ASSERT(a_copy_below, cp_valid_s1 |-> (cp_addr_s1 < COPY_CNT), "copy writes past the last row")
	`TCW_ASSERT(a_result_source, $rose(out_valid_q) |-> $past((state_q == S_EXEC) || (state_q == S_WAIT)), "result without a request")

endmodule
